FILE: sv/bdvd_pkg.sv
// Shared types and constants for the bounded deque with value delete.
// Used by bdvd_cell and bounded_deque_with_value_delete_core; no dependencies.
package bdvd_pkg;

	localparam int VALUE_W = 32;
	localparam int FUNC_W = 4;
	localparam int STATUS_W = 2;
	localparam int TUSER_OUT_W = 1 + STATUS_W;

	typedef enum logic [FUNC_W-1:0] {
		OP_PUSH_FRONT = 4'd0,
		OP_PUSH_BACK  = 4'd1,
		OP_POP_FRONT  = 4'd2,
		OP_POP_BACK   = 4'd3,
		OP_REMOVE     = 4'd4,
		OP_CLEAR      = 4'd5,
		OP_READ_ALL   = 4'd6,
		OP_READ_FIRST = 4'd7,
		OP_READ_LAST  = 4'd8
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SKIP,
		S_EMIT
	} state_t;

	// Per-cell control.
	typedef struct packed {
		logic put_operand;
		logic take_left;
		logic take_right;
		logic rd_load;
		logic rd_shift;
	} cell_ctl_t;

endpackage

FILE: sv/bdvd_cell.sv
// One storage cell of the deque chain: an entry register and a read-out shadow register.
// Depends on bdvd_pkg for the control struct and word width.
module bdvd_cell (
	input  logic                         clk,
	input  bdvd_pkg::cell_ctl_t          ctl,
	input  logic [bdvd_pkg::VALUE_W-1:0] operand,
	input  logic [bdvd_pkg::VALUE_W-1:0] left_ent,
	input  logic [bdvd_pkg::VALUE_W-1:0] right_ent,
	input  logic [bdvd_pkg::VALUE_W-1:0] right_rd,
	output logic [bdvd_pkg::VALUE_W-1:0] ent,
	output logic [bdvd_pkg::VALUE_W-1:0] rd,
	output logic                         match
);
	import bdvd_pkg::*;

	logic [VALUE_W-1:0] ent_q;
	logic [VALUE_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		priority if (ctl.put_operand) begin
			ent_q <= operand;
		end else if (ctl.take_left) begin
			ent_q <= left_ent;
		end else if (ctl.take_right) begin
			ent_q <= right_ent;
		end else begin
			ent_q <= ent_q;
		end
	end

	// The shadow chain moves toward the front so the front cell always holds the next word out.
	always_ff @(posedge clk) begin
		priority if (ctl.rd_load) begin
			rd_q <= ent_q;
		end else if (ctl.rd_shift) begin
			rd_q <= right_rd;
		end else begin
			rd_q <= rd_q;
		end
	end

	assign ent   = ent_q;
	assign rd    = rd_q;
	assign match = (ent_q == operand);

endmodule

FILE: sv/bounded_deque_with_value_delete_core.sv
// Top level of the bounded deque with value delete: control sequencer and a chain of cells.
// Depends on bdvd_pkg and bdvd_cell.
//
//  channel | direction | tdata       | tuser (low bit up)     | tlast
//  s_      | in        | operand     | func                   | -
//  m_      | out       | value       | has_entry, status      | last
//
// Push, pop, remove and clear complete on acceptance: cells shift or load in parallel as needed.
// A read loads the shadow chain, then emits one beat per cycle from the front cell when not stalled;
// read last k first shifts the leading occupancy minus k words out of the chain without output.
// Reset clears occupancy and the sequencer; entry contents stay undefined until written.
// A stalled output beat holds the sequencer; in idle a new beat is accepted while the output is empty or taken.
module bounded_deque_with_value_delete_core #(
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [bdvd_pkg::VALUE_W-1:0]     s_tdata,  // [31:0] operand
	input  logic [bdvd_pkg::FUNC_W-1:0]      s_tuser,  // [3:0] func
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [bdvd_pkg::VALUE_W-1:0]     m_tdata,  // [31:0] value
	output logic [bdvd_pkg::TUSER_OUT_W-1:0] m_tuser,  // [0] has_entry, [2:1] status
	output logic                             m_tlast
);
	import bdvd_pkg::*;

	localparam int OCC_W = $clog2(DEPTH + 1);

	state_t state_q, state_d;
	logic [OCC_W-1:0] occ_q, occ_d;
	logic [OCC_W-1:0] cnt_q, cnt_d;
	logic [OCC_W-1:0] skip_q, skip_d;

	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic               out_has_q;
	logic               out_last_q;
	status_t            out_status_q;

	logic               out_ld;
	logic [VALUE_W-1:0] out_value_d;
	logic               out_has_d;
	logic               out_last_d;
	status_t            out_status_d;

	logic out_free;
	logic accept;
	func_t func;

	logic [VALUE_W-1:0] ent_v [DEPTH];
	logic [VALUE_W-1:0] rd_v  [DEPTH];
	cell_ctl_t          ctl_v [DEPTH];
	logic [DEPTH-1:0]   match_v;
	logic [DEPTH-1:0]   hit_v;
	logic [DEPTH-1:0]   hit_pre;

	logic             is_read;
	logic [OCC_W-1:0] rd_count;
	logic [OCC_W-1:0] rd_skip;
	logic [OCC_W-1:0] k_clamp;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign func     = func_t'(s_tuser);

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic [VALUE_W-1:0] left_ent;
			logic [VALUE_W-1:0] right_ent;
			logic [VALUE_W-1:0] right_rd;
			if (gi == 0) begin : g_front
				assign left_ent = '0;
			end else begin : g_mid_l
				assign left_ent = ent_v[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_back
				assign right_ent = '0;
				assign right_rd  = '0;
			end else begin : g_mid_r
				assign right_ent = ent_v[gi+1];
				assign right_rd  = rd_v[gi+1];
			end
			bdvd_cell u_cell (
				.clk       (clk),
				.ctl       (ctl_v[gi]),
				.operand   (s_tdata),
				.left_ent  (left_ent),
				.right_ent (right_ent),
				.right_rd  (right_rd),
				.ent       (ent_v[gi]),
				.rd        (rd_v[gi]),
				.match     (match_v[gi])
			);
		end
	endgenerate

	// Only cells below the occupancy hold entries.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			hit_v[i] = match_v[i] && (OCC_W'(i) < occ_q);
		end
	end

	// Prefix OR: a cell at or behind the first hit closes the gap by taking its right neighbor.
	always_comb begin
		logic [DEPTH-1:0] acc;
		acc = hit_v;
		for (int s = 1; s < DEPTH; s = s * 2) begin
			acc = acc | (acc << s);
		end
		hit_pre = acc;
	end

	// Read length and lead-in for the three read kinds; a negative k reads nothing.
	always_comb begin
		if (s_tdata[VALUE_W-1]) begin
			k_clamp = '0;
		end else if (s_tdata > VALUE_W'(occ_q)) begin
			k_clamp = occ_q;
		end else begin
			k_clamp = s_tdata[OCC_W-1:0];
		end
		is_read  = 1'b0;
		rd_count = '0;
		rd_skip  = '0;
		unique case (func)
			OP_READ_ALL: begin
				is_read  = 1'b1;
				rd_count = occ_q;
			end
			OP_READ_FIRST: begin
				is_read  = 1'b1;
				rd_count = k_clamp;
			end
			OP_READ_LAST: begin
				is_read  = 1'b1;
				rd_count = k_clamp;
				rd_skip  = occ_q - k_clamp;
			end
			default: begin
				is_read = 1'b0;
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && is_read && (rd_count != '0)) begin
					state_d = (rd_skip != '0) ? S_SKIP : S_EMIT;
				end
			end
			S_SKIP: begin
				if (skip_q == OCC_W'(1)) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_free && (cnt_q == OCC_W'(1))) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Outputs: cell controls, counters and the next output beat.
	always_comb begin
		out_ld       = 1'b0;
		out_value_d  = '0;
		out_has_d    = 1'b0;
		out_last_d   = 1'b1;
		out_status_d = ST_OK;
		occ_d        = occ_q;
		cnt_d        = cnt_q;
		skip_d       = skip_q;
		for (int i = 0; i < DEPTH; i++) begin
			ctl_v[i] = '0;
		end
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					out_ld = 1'b1;
					unique case (func)
						OP_PUSH_FRONT: begin
							if (occ_q == OCC_W'(DEPTH)) begin
								out_status_d = ST_FULL;
							end else begin
								for (int i = 0; i < DEPTH; i++) begin
									ctl_v[i].put_operand = (i == 0);
									ctl_v[i].take_left   = (i != 0);
								end
								occ_d = occ_q + OCC_W'(1);
							end
						end
						OP_PUSH_BACK: begin
							if (occ_q == OCC_W'(DEPTH)) begin
								out_status_d = ST_FULL;
							end else begin
								for (int i = 0; i < DEPTH; i++) begin
									ctl_v[i].put_operand = (OCC_W'(i) == occ_q);
								end
								occ_d = occ_q + OCC_W'(1);
							end
						end
						OP_POP_FRONT: begin
							if (occ_q == '0) begin
								out_status_d = ST_EMPTY;
							end else begin
								for (int i = 0; i < DEPTH; i++) begin
									ctl_v[i].take_right = 1'b1;
								end
								occ_d = occ_q - OCC_W'(1);
							end
						end
						OP_POP_BACK: begin
							if (occ_q == '0) begin
								out_status_d = ST_EMPTY;
							end else begin
								occ_d = occ_q - OCC_W'(1);
							end
						end
						OP_REMOVE: begin
							if (occ_q == '0) begin
								out_status_d = ST_EMPTY;
							end else if (hit_pre[DEPTH-1]) begin
								for (int i = 0; i < DEPTH; i++) begin
									ctl_v[i].take_right = hit_pre[i];
								end
								occ_d = occ_q - OCC_W'(1);
							end else begin
								out_status_d = ST_NOTFOUND;
							end
						end
						OP_CLEAR: begin
							occ_d = '0;
						end
						OP_READ_ALL, OP_READ_FIRST, OP_READ_LAST: begin
							if (rd_count == '0) begin
								out_status_d = (occ_q == '0) ? ST_EMPTY : ST_OK;
							end else begin
								out_ld = 1'b0;
								for (int i = 0; i < DEPTH; i++) begin
									ctl_v[i].rd_load = 1'b1;
								end
								cnt_d  = rd_count;
								skip_d = rd_skip;
							end
						end
						default: begin
							out_status_d = ST_OK;
						end
					endcase
				end
			end
			S_SKIP: begin
				for (int i = 0; i < DEPTH; i++) begin
					ctl_v[i].rd_shift = 1'b1;
				end
				skip_d = skip_q - OCC_W'(1);
			end
			S_EMIT: begin
				if (out_free) begin
					out_ld      = 1'b1;
					out_value_d = rd_v[0];
					out_has_d   = 1'b1;
					out_last_d  = (cnt_q == OCC_W'(1));
					for (int i = 0; i < DEPTH; i++) begin
						ctl_v[i].rd_shift = 1'b1;
					end
					cnt_d = cnt_q - OCC_W'(1);
				end
			end
			default: begin
				out_ld = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
			cnt_q       <= '0;
			skip_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
			cnt_q   <= cnt_d;
			skip_q  <= skip_d;
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			out_value_q  <= out_value_d;
			out_has_q    <= out_has_d;
			out_last_q   <= out_last_d;
			out_status_q <= out_status_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tuser  = {out_status_q, out_has_q};
	assign m_tlast  = out_last_q;

endmodule
